// File: src/framed_gamepad_packet_parser_top_macros.svh
// Assertion macros used by the checker file.
`ifndef FRAMED_GAMEPAD_PACKET_PARSER_TOP_MACROS_SVH
`define FRAMED_GAMEPAD_PACKET_PARSER_TOP_MACROS_SVH

// Implication in the same cycle, held off while reset is low.
`define FGPP_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define FGPP_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fgpp_pkg.sv
`timescale 1ns / 1ps
package fgpp_pkg;

    localparam logic [7:0] SYNC_FIRST      = 8'hAA;
    localparam logic [7:0] SYNC_SECOND     = 8'h55;
    localparam logic [7:0] GAMEPAD_ID_RST  = 8'h01;
    localparam int         PAYLOAD_KEEP    = 7;
    localparam int         KEEP_W          = $clog2(PAYLOAD_KEEP);
    localparam int         GAMEPAD_MIN_LEN = 11;
    localparam int         FIRST_BODY_POS  = 3;
    localparam int         MAX_FRAME_DEF   = 40;
    localparam int         MIN_FRAME_DEF   = 5;
    localparam int         QUEUE_DEPTH     = 2;
    localparam int         RESULT_W        = 48;

    typedef struct packed {
        logic [15:0]        buttons;
        logic signed [7:0]  right_y;
        logic signed [7:0]  right_x;
        logic signed [7:0]  left_y;
        logic signed [7:0]  left_x;
    } t_result;

endpackage

// File: src/fgpp_front.sv
`timescale 1ns / 1ps
module fgpp_front
    import fgpp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_DEF,
    parameter int MIN_FRAME_LEN = MIN_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_result    o_result
);

    localparam logic [7:0] MAX_B = 8'(MAX_FRAME_LEN);
    localparam logic [7:0] MIN_B = 8'(MIN_FRAME_LEN);

    typedef enum logic [3:0] {
        ST_SYNC1 = 4'b0001,
        ST_SYNC2 = 4'b0010,
        ST_LEN   = 4'b0100,
        ST_BODY  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_id;
    logic [7:0]  r_pay [PAYLOAD_KEEP];

    logic        accept;
    logic        is_chk;
    logic [5:0]  idx;
    logic        keep;
    logic        good;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign is_chk  = !((7'(r_pos) + 7'd1) < {1'b0, r_len});
    assign idx     = r_pos - 6'(FIRST_BODY_POS);
    assign keep    = idx < 6'(PAYLOAD_KEEP);
    assign good    = (i_byte == r_sum) && (r_pay[0] == r_id)
                     && (r_len >= 6'(GAMEPAD_MIN_LEN));
    assign o_push  = accept && (r_state == ST_BODY) && is_chk && good;

    assign o_result.left_x  = r_pay[1];
    assign o_result.left_y  = r_pay[2];
    assign o_result.right_x = r_pay[3];
    assign o_result.right_y = r_pay[4];
    assign o_result.buttons = {r_pay[6], r_pay[5]};

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        if (accept) begin
            unique case (r_state)
                ST_SYNC1: begin
                    if (i_byte == SYNC_FIRST) begin
                        n_state = ST_SYNC2;
                    end
                end
                ST_SYNC2: begin
                    n_state = (i_byte == SYNC_SECOND) ? ST_LEN : ST_SYNC1;
                end
                ST_LEN: begin
                    if (i_byte < MIN_B || i_byte > MAX_B) begin
                        n_state = ST_SYNC1;
                    end else begin
                        n_state = ST_BODY;
                        n_len   = i_byte[5:0];
                        n_sum   = SYNC_FIRST + SYNC_SECOND + i_byte;
                        n_pos   = 6'(FIRST_BODY_POS);
                    end
                end
                ST_BODY: begin
                    if (is_chk) begin
                        // checksum byte ends the frame, good or not
                        n_state = ST_SYNC1;
                    end else begin
                        n_sum = r_sum + i_byte;
                        n_pos = r_pos + 6'd1;
                    end
                end
                default: n_state = ST_SYNC1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC1;
            r_pos   <= '0;
            r_len   <= '0;
            r_sum   <= '0;
            r_id    <= GAMEPAD_ID_RST;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
            if (i_cfg_we) begin
                r_id <= i_cfg_wdata;
            end
        end
    end

    // keep the first payload bytes only
    always_ff @(posedge i_clk) begin
        if (accept && (r_state == ST_BODY) && !is_chk && keep) begin
            r_pay[idx[KEEP_W-1:0]] <= i_byte;
        end
    end

endmodule

// File: src/fgpp_queue.sv
`timescale 1ns / 1ps
module fgpp_queue
    import fgpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/fgpp_back.sv
`timescale 1ns / 1ps
module fgpp_back
    import fgpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_result             i_data,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RESULT_W-1:0] o_data
);

    logic    r_valid;
    t_result r_data;
    logic    load;

    // refill the output register whenever it is empty or being taken
    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !i_empty;
    assign o_valid = r_valid;
    assign o_data  = {r_data.buttons, r_data.right_y, r_data.right_x,
                      r_data.left_y, r_data.left_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule

// File: src/framed_gamepad_packet_parser_top.sv
// Channel   | Direction | tdata fields (low bit up)
// s_axis    | in        | rx_byte[7:0]
// m_axis    | out       | left_x[7:0] left_y[15:8] right_x[23:16] right_y[31:24] buttons[47:32]
// cfg       | in        | gamepad_frame_id[7:0], written whenever i_cfg_we is high
//
// One byte is taken every cycle while the queue is not full; a result enters a two-entry result queue at the edge
// that takes its checksum byte and moves into the output register once that register is empty or being taken.
// Input stalls only when the queue is full, set by back pressure on m_axis.
// Reset is synchronous, active low; it clears the parser, the queue and the output valid.
`timescale 1ns / 1ps
module framed_gamepad_packet_parser_top
    import fgpp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_DEF,
    parameter int MIN_FRAME_LEN = MIN_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,      // gamepad_frame_id
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // rx_byte
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [RESULT_W-1:0] o_m_axis_tdata    // left_x, left_y, right_x, right_y, buttons
);

    logic    push;
    logic    full;
    logic    pop;
    logic    empty;
    t_result front_res;
    t_result queue_res;

    fgpp_front #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN),
        .MIN_FRAME_LEN(MIN_FRAME_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_full     (full),
        .o_push     (push),
        .o_result   (front_res)
    );

    fgpp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_res),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (queue_res)
    );

    fgpp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_data (queue_res),
        .o_pop  (pop),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_data (o_m_axis_tdata)
    );

endmodule

// File: src/fgpp_checker.sv
`timescale 1ns / 1ps
`include "framed_gamepad_packet_parser_top_macros.svh"
module fgpp_checker
    import fgpp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [RESULT_W-1:0] o_m_axis_tdata
);

    logic out_stall;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `FGPP_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_m_axis_tvalid, "valid after reset")
    `FGPP_ASSERT(a_hold_valid, i_clk, i_rst_n, $past(i_rst_n) && $past(out_stall), o_m_axis_tvalid, "result dropped while stalled")
    `FGPP_ASSERT(a_hold_data, i_clk, i_rst_n, $past(i_rst_n) && $past(out_stall), $stable(o_m_axis_tdata), "result changed while stalled")
    `FGPP_ASSERT(a_rise_after_byte, i_clk, i_rst_n, $past(i_rst_n, 2) && $rose(o_m_axis_tvalid), $past(i_s_axis_tvalid && o_s_axis_tready, 2), "result without checksum byte")
    `FGPP_ASSERT(a_stall_needs_output, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with output empty")

endmodule

bind framed_gamepad_packet_parser_top fgpp_checker u_fgpp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);

// File: tb/sv/framed_gamepad_packet_parser_top_tb.sv
`timescale 1ns / 1ps
module framed_gamepad_packet_parser_top_tb;
    import fgpp_pkg::*;

    localparam logic [5:0] POS_SYNC1 = 6'd0;
    localparam logic [5:0] POS_SYNC2 = 6'd1;
    localparam logic [5:0] POS_LEN   = 6'd2;
    localparam int         PHASES    = 5;
    localparam int         PHASE_BYTES = 320;

    // Frame parser predictor plus the queue of gamepad reports still owed by the block.
    class gamepad_frame_tracker;
        logic [7:0] pad_id;
        logic [5:0] parse_pos;
        logic [5:0] frame_len;
        logic [7:0] run_sum;
        logic [7:0] payload [PAYLOAD_KEEP];
        t_result    awaited [$];
        int         mismatches;
        int         reports_checked;

        function new();
            pad_id          = GAMEPAD_ID_RST;
            parse_pos       = POS_SYNC1;
            frame_len       = '0;
            run_sum         = '0;
            mismatches      = 0;
            reports_checked = 0;
            foreach (payload[k]) payload[k] = '0;
        endfunction

        function void set_pad_id(input logic [7:0] v);
            pad_id = v;
        endfunction

        function void note_byte(input logic [7:0] b);
            t_result r;
            int      k;
            case (parse_pos)
                POS_SYNC1: begin
                    if (b == SYNC_FIRST) parse_pos = POS_SYNC2;
                end
                POS_SYNC2: begin
                    // a bad second header is not retried as a first header
                    parse_pos = (b == SYNC_SECOND) ? POS_LEN : POS_SYNC1;
                end
                POS_LEN: begin
                    if (b < MIN_FRAME_DEF || b > MAX_FRAME_DEF) begin
                        parse_pos = POS_SYNC1;
                    end else begin
                        frame_len = b[5:0];
                        run_sum   = SYNC_FIRST + SYNC_SECOND + b;
                        parse_pos = 6'(FIRST_BODY_POS);
                    end
                end
                default: begin
                    if (parse_pos + 1 < frame_len) begin
                        k = parse_pos - FIRST_BODY_POS;
                        if (k < PAYLOAD_KEEP) payload[k] = b;
                        run_sum   = run_sum + b;
                        parse_pos = parse_pos + 6'd1;
                    end else begin
                        if (b == run_sum && payload[0] == pad_id &&
                            frame_len >= GAMEPAD_MIN_LEN) begin
                            r.left_x  = payload[1];
                            r.left_y  = payload[2];
                            r.right_x = payload[3];
                            r.right_y = payload[4];
                            r.buttons = {payload[6], payload[5]};
                            awaited.push_back(r);
                        end
                        parse_pos = POS_SYNC1;
                    end
                end
            endcase
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_report(input t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("report %h with none outstanding", got));
            end else begin
                want = awaited.pop_front();
                reports_checked++;
                if (got.left_x != want.left_x)
                    report_mismatch($sformatf("left_x %0d, want %0d", got.left_x, want.left_x));
                if (got.left_y != want.left_y)
                    report_mismatch($sformatf("left_y %0d, want %0d", got.left_y, want.left_y));
                if (got.right_x != want.right_x)
                    report_mismatch($sformatf("right_x %0d, want %0d",
                                              got.right_x, want.right_x));
                if (got.right_y != want.right_y)
                    report_mismatch($sformatf("right_y %0d, want %0d",
                                              got.right_y, want.right_y));
                if (got.buttons != want.buttons)
                    report_mismatch($sformatf("buttons %h, want %h", got.buttons, want.buttons));
            end
        endtask
    endclass

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [7:0]          i_cfg_wdata     = 8'h00;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata  = 8'h00;    // rx_byte
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] o_m_axis_tdata;             // left_x, left_y, right_x, right_y, buttons

    gamepad_frame_tracker tracker = new();

    logic [15:0] rx_cycle = '0;
    logic [7:0]  body_preset [$];
    int          burst_left = 8;
    int          bytes_sent = 0;
    int          frames_sent = 0;

    framed_gamepad_packet_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Check a report on each accepted request, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_report(t_result'(o_m_axis_tdata));
        rx_cycle <= rx_cycle + 16'd1;
        case (rx_cycle[9:8])
            2'd0:    i_m_axis_tready <= 1'b1;
            2'd1:    i_m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    i_m_axis_tready <= (rx_cycle[2:0] == 3'd0);
            default: i_m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic push_byte(input logic [7:0] b);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_byte(b);
        bytes_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Take body bytes from body_preset while it holds any, random after that.
    task automatic send_frame(input int len, input logic [7:0] id, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = SYNC_FIRST + SYNC_SECOND + 8'(len) + id;
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'(len));
        push_byte(id);
        for (int k = 4; k < len - 1; k++) begin
            if (body_preset.size() != 0) b = body_preset.pop_front();
            else b = 8'($urandom);
            push_byte(b);
            sum = sum + b;
        end
        push_byte(corrupt ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum);
        frames_sent++;
    endtask

    task automatic send_random_item();
        int         pick;
        int         len;
        logic [7:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            pick = $urandom_range(0, 99);
            len  = (pick < 8) ? MAX_FRAME_DEF : (pick < 16) ? GAMEPAD_MIN_LEN
                                                            : $urandom_range(11, 18);
            send_frame(len, tracker.pad_id, $urandom_range(0, 9) == 0);
        end else if (pick < 72) begin
            id  = tracker.pad_id ^ 8'($urandom_range(1, 255));
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(5, 16);
            send_frame(len, id, 1'b0);
        end else if (pick < 80) begin
            send_frame($urandom_range(5, 10), tracker.pad_id, 1'b0);
        end else if (pick < 88) begin
            push_byte(SYNC_FIRST);
            if ($urandom_range(0, 1) == 0) begin
                push_byte(8'($urandom_range(0, 255)) ^ 8'h00 | 8'h00
                          ^ (($urandom_range(0, 1) == 0) ? SYNC_FIRST : 8'h00));
            end else begin
                push_byte(SYNC_SECOND);
                push_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 4))
                                                      : 8'($urandom_range(41, 255)));
            end
        end else if (pick < 94) begin
            // drop the tail: the next frame's bytes land in this one's body
            len = $urandom_range(5, 40);
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(8'(len));
            repeat ($urandom_range(0, len - 4)) push_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        end
    endtask

    task automatic write_pad_id(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        tracker.set_pad_id(v);
        i_cfg_we    <= 1'b0;
    endtask

    // Hold the input until every report is back, then let the pipeline settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] ids [PHASES];
        int         phase_start;
        ids = '{GAMEPAD_ID_RST, 8'h00, 8'hFF, SYNC_SECOND, 8'h00};
        ids[PHASES-1] = 8'($urandom_range(0, 255));
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) write_pad_id(ids[ph]);
            if (ph == 0) begin
                push_byte(8'h00);                        // stray byte while idle
                push_byte(SYNC_FIRST);
                push_byte(SYNC_FIRST);                   // bad second header, no resync
                push_byte(SYNC_FIRST);
                push_byte(SYNC_SECOND);
                push_byte(8'(MIN_FRAME_DEF - 1));        // length just too short
                push_byte(SYNC_FIRST);
                push_byte(SYNC_SECOND);
                push_byte(8'(MAX_FRAME_DEF + 1));        // length just too long
                send_frame(MIN_FRAME_DEF, GAMEPAD_ID_RST, 1'b1);
                body_preset = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'hFF, 8'hFF};
                send_frame(GAMEPAD_MIN_LEN, GAMEPAD_ID_RST, 1'b0);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_random_item();
            drain();
        end

        $display("Sent %0d bytes in %0d frames over %0d gamepad id settings.",
                 bytes_sent, frames_sent, PHASES);
        $display("Checked %0d gamepad reports, %0d mismatches.",
                 tracker.reports_checked, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d reports outstanding.", tracker.awaited.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/fgpp_pkg.sv
src/fgpp_front.sv
src/fgpp_queue.sv
src/fgpp_back.sv
src/framed_gamepad_packet_parser_top.sv
src/fgpp_checker.sv
tb/sv/framed_gamepad_packet_parser_top_tb.sv
